>>> hdl/cbfr_pkg.sv
// shared types and constants for the checksummed bit frame receiver
package cbfr_pkg;

  // field widths
  localparam int unsigned GapWidth  = 20;
  localparam int unsigned ByteWidth = 8;
  localparam int unsigned CntWidth  = 3;

  // stream word widths (fields packed from bit 0, padded to whole bytes)
  localparam int unsigned InDataWidth  = 24;
  localparam int unsigned OutDataWidth = 16;

  // configuration register indexes
  localparam int unsigned CfgIndexWidth = 1;
  localparam logic [CfgIndexWidth-1:0] RegDecodeMode = 1'd0;
  localparam logic [CfgIndexWidth-1:0] RegThreshold  = 1'd1;

  // decode modes
  localparam logic ModeLevel  = 1'b0;
  localparam logic ModeTiming = 1'b1;

  // result kinds
  localparam logic KindChar    = 1'b0;
  localparam logic KindVerdict = 1'b1;

  // byte constants
  localparam logic [ByteWidth-1:0] Terminator = 8'd10;
  localparam logic [ByteWidth-1:0] LowChar    = 8'd32;
  localparam logic [ByteWidth-1:0] HighCharM0 = 8'd127;
  localparam logic [ByteWidth-1:0] HighCharM1 = 8'd126;

  localparam logic [GapWidth-1:0]  ThreshReset  = 20'd6000;
  localparam logic [CntWidth-1:0]  BitsPerByteM1 = 3'd7;

  // one line event
  typedef struct packed {
    logic [GapWidth-1:0] gap_us;
    logic                bit_value;
  } item_t;

  // one result
  typedef struct packed {
    logic                 result_kind;
    logic                 frame_ok;
    logic [ByteWidth-1:0] char_byte;
  } result_t;

  // configuration in force
  typedef struct packed {
    logic                decode_mode;
    logic [GapWidth-1:0] short_gap_threshold_us;
  } cfg_t;

  // handshake between input stage and decoder
  typedef struct packed {
    logic valid;
    logic advance;
  } stage_ctl_t;

endpackage

>>> hdl/cbfr_in_stage.sv
// input register stage holding one accepted line event
module cbfr_in_stage (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  cbfr_pkg::item_t      in_item,
  input  logic                 out_free,
  output cbfr_pkg::stage_ctl_t ctl,
  output cbfr_pkg::item_t      item
);

  logic valid;
  logic valid_next;

  // held item moves on whenever the result register can take a result
  assign ctl.valid   = valid;
  assign ctl.advance = valid & out_free;
  assign in_ready    = ~rst & (~valid | out_free);

  always_comb begin
    valid_next = valid;
    if (in_valid && in_ready) begin
      valid_next = 1'b1;
    end else if (ctl.advance) begin
      valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  // payload capture
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

endmodule

>>> hdl/cbfr_decoder.sv
// bit recovery, byte assembly, checksum and range check for one event
module cbfr_decoder (
  input  logic                 clk,
  input  logic                 rst,
  input  cbfr_pkg::cfg_t       cfg,
  input  cbfr_pkg::stage_ctl_t ctl,
  input  cbfr_pkg::item_t      item,
  output logic                 res_valid,
  output cbfr_pkg::result_t    res
);

  logic [cbfr_pkg::ByteWidth-1:0] shift_bits, shift_bits_next;
  logic [cbfr_pkg::CntWidth-1:0]  bits_left, bits_left_next;
  logic                           pair_phase, pair_phase_next;
  logic                           header_seen, header_seen_next;
  logic [cbfr_pkg::ByteWidth-1:0] header_byte, header_byte_next;
  logic [cbfr_pkg::ByteWidth-1:0] running_sum, running_sum_next;
  logic                           range_error, range_error_next;

  logic                           fire;
  logic                           first_pulse;
  logic                           bit_in;
  logic [cbfr_pkg::ByteWidth-1:0] shifted;
  logic [cbfr_pkg::ByteWidth-1:0] sum_with;
  logic [cbfr_pkg::ByteWidth-1:0] high_char;
  logic                           out_of_range;

  assign fire        = ctl.advance;
  assign first_pulse = (cfg.decode_mode == cbfr_pkg::ModeTiming) && !pair_phase;
  assign bit_in      = (cfg.decode_mode == cbfr_pkg::ModeLevel) ? item.bit_value
                     : (item.gap_us < cfg.short_gap_threshold_us);
  assign shifted     = {shift_bits[cbfr_pkg::ByteWidth-2:0], bit_in};
  assign sum_with    = running_sum + shifted;
  assign high_char   = (cfg.decode_mode == cbfr_pkg::ModeLevel) ? cbfr_pkg::HighCharM0
                     : cbfr_pkg::HighCharM1;
  assign out_of_range = (shifted < cbfr_pkg::LowChar) || (shifted > high_char);

  // next state and result for the event in the input register
  always_comb begin
    shift_bits_next  = shift_bits;
    bits_left_next   = bits_left;
    pair_phase_next  = pair_phase;
    header_seen_next = header_seen;
    header_byte_next = header_byte;
    running_sum_next = running_sum;
    range_error_next = range_error;
    res_valid        = 1'b0;
    res.result_kind  = cbfr_pkg::KindChar;
    res.char_byte    = shifted;
    res.frame_ok     = 1'b0;
    if (fire) begin
      if (first_pulse) begin
        pair_phase_next = 1'b1;
      end else begin
        if (cfg.decode_mode == cbfr_pkg::ModeTiming) begin
          pair_phase_next = 1'b0;
        end
        if (bits_left != '0) begin
          shift_bits_next = shifted;
          bits_left_next  = bits_left - 1'b1;
        end else begin
          shift_bits_next = '0;
          bits_left_next  = cbfr_pkg::BitsPerByteM1;
          priority if (!header_seen) begin
            header_byte_next = shifted;
            header_seen_next = 1'b1;
          end else if (shifted == cbfr_pkg::Terminator) begin
            res_valid        = 1'b1;
            res.result_kind  = cbfr_pkg::KindVerdict;
            res.frame_ok     = !range_error && (header_byte == sum_with);
            header_seen_next = 1'b0;
            running_sum_next = '0;
            range_error_next = 1'b0;
          end else begin
            res_valid        = 1'b1;
            running_sum_next = sum_with;
            range_error_next = range_error | out_of_range;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_bits  <= '0;
      bits_left   <= cbfr_pkg::BitsPerByteM1;
      pair_phase  <= 1'b0;
      header_seen <= 1'b0;
      header_byte <= '0;
      running_sum <= '0;
      range_error <= 1'b0;
    end else begin
      shift_bits  <= shift_bits_next;
      bits_left   <= bits_left_next;
      pair_phase  <= pair_phase_next;
      header_seen <= header_seen_next;
      header_byte <= header_byte_next;
      running_sum <= running_sum_next;
      range_error <= range_error_next;
    end
  end

endmodule

>>> hdl/cbfr_out_stage.sv
// result register driving the output stream
module cbfr_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              res_valid,
  input  cbfr_pkg::result_t res,
  output logic              out_free,
  output logic              out_valid,
  input  logic              out_ready,
  output cbfr_pkg::result_t out_res
);

  logic valid;
  logic valid_next;

  assign out_free  = ~valid | out_ready;
  assign out_valid = valid;

  always_comb begin
    valid_next = valid;
    if (res_valid) begin
      valid_next = 1'b1;
    end else if (out_ready) begin
      valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  // payload capture
  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_res <= res;
    end
  end

endmodule

>>> hdl/checksummed_bit_frame_receiver_core.sv
// top level of the checksummed bit frame receiver
//
// Takes one line event per transaction on the s_axis channel and rebuilds
// framed bytes. In level mode each event is one bit; in timing mode events
// pair up and the second of a pair gives 1 when its gap is below the
// threshold. Bytes are built MSB first; the first byte of a frame is the
// header checksum and is consumed. Later bytes leave on m_axis as payload
// characters (tuser 0); byte 10 ends the frame with a verdict (tuser 1).
// An event waits in the input register; the decoder feeds the result
// register. Throughput is one event per cycle while the result register
// can take a result, set by the single decode stage between the input
// register and the result register. If m_axis stalls, the result
// register holds, the input register holds its event, and s_axis_tready
// drops once both are full. Configuration registers are written through
// cfg_wr_en while idle; the user must ensure it, the block does not.
// Synchronous reset empties both stages, clears the byte and frame state
// and restores level mode with a threshold of 6000 us; tready is low
// during reset.
module checksummed_bit_frame_receiver_core (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // [0] bit_value, [20:1] gap_us, [23:21] zero
  input  logic [cbfr_pkg::InDataWidth-1:0]      s_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // [7:0] char_byte, [8] frame_ok, [15:9] zero
  output logic [cbfr_pkg::OutDataWidth-1:0]     m_axis_tdata,
  // [0] result_kind
  output logic                                  m_axis_tuser,
  input  logic                                  cfg_wr_en,
  input  logic [cbfr_pkg::CfgIndexWidth-1:0]    cfg_index,
  input  logic [cbfr_pkg::GapWidth-1:0]         cfg_data
);

  cbfr_pkg::cfg_t       cfg;
  cbfr_pkg::item_t      in_item;
  cbfr_pkg::item_t      item;
  cbfr_pkg::stage_ctl_t ctl;
  cbfr_pkg::result_t    res;
  cbfr_pkg::result_t    out_res;
  logic                 res_valid;
  logic                 out_free;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.decode_mode            <= cbfr_pkg::ModeLevel;
      cfg.short_gap_threshold_us <= cbfr_pkg::ThreshReset;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        cbfr_pkg::RegDecodeMode: cfg.decode_mode <= cfg_data[0];
        cbfr_pkg::RegThreshold:  cfg.short_gap_threshold_us <= cfg_data;
        default: ;
      endcase
    end
  end

  // input unpacking
  assign in_item.bit_value = s_axis_tdata[0];
  assign in_item.gap_us    = s_axis_tdata[cbfr_pkg::GapWidth:1];

  cbfr_in_stage u_in_stage (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_item  (in_item),
    .out_free (out_free),
    .ctl      (ctl),
    .item     (item)
  );

  cbfr_decoder u_decoder (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .ctl       (ctl),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  cbfr_out_stage u_out_stage (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .out_free  (out_free),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (out_res)
  );

  // output packing
  assign m_axis_tdata = {7'd0, out_res.frame_ok, out_res.char_byte};
  assign m_axis_tuser = out_res.result_kind;

endmodule

>>> hdl/cbfr_checker.sv
// port-level checks for the frame receiver, bound to the top level
module cbfr_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [cbfr_pkg::OutDataWidth-1:0] m_axis_tdata,
  input logic                              m_axis_tuser
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // a verdict always carries the terminator byte
  a_verdict_byte: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == cbfr_pkg::KindVerdict)
      |-> m_axis_tdata[7:0] == cbfr_pkg::Terminator)
    else $error("verdict without terminator byte");

  // payload characters never claim a good frame
  a_char_no_ok: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == cbfr_pkg::KindChar) |-> !m_axis_tdata[8])
    else $error("frame_ok set on payload character");

  // a fresh result follows an input transaction
  a_result_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) && !$past(rst) |-> $past(s_axis_tvalid && s_axis_tready, 2))
    else $error("result without input transaction");

endmodule

bind checksummed_bit_frame_receiver_core cbfr_checker u_cbfr_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
